>>> rtl/m3i_pkg.sv
package m3i_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int ENT_W     = 32;
  localparam int ADJ_W     = 2 * ENT_W;
  localparam int DET_W     = ADJ_W + ENT_W + 2;
  localparam int DMAG_W    = DET_W - 1;
  localparam int THR_W     = 31;
  localparam int THR_RST   = 7;

  // divider sizing
  localparam int Q_W    = ENT_W + 1;
  localparam int NSH_W  = ADJ_W + 2 * FRAC_BITS + 1;
  localparam int NUM_W  = (NSH_W > DMAG_W ? NSH_W : DMAG_W) + 1;
  localparam int R0_W   = NUM_W - Q_W;
  localparam int DEN_W  = DMAG_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int SV_W   = ADJ_W + 1 - FRAC_BITS;
  localparam int N_LANE = 9;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [ADJ_W-1:0] adj_t;

  typedef struct packed {
    ent_t m00; ent_t m01; ent_t m02;
    ent_t m10; ent_t m11; ent_t m12;
    ent_t m20; ent_t m21; ent_t m22;
  } mat_t;

  typedef struct packed {
    ent_t r00; ent_t r01; ent_t r02;
    ent_t r10; ent_t r11; ent_t r12;
    ent_t r20; ent_t r21; ent_t r22;
    logic singular;
    logic saturated;
  } inv_t;

  // one adjugate entry with the shared determinant data
  typedef struct packed {
    logic              valid;
    adj_t              adj;
    logic [DMAG_W-1:0] dmag;
    logic              dneg;
    logic              singular;
  } lane_in_t;

  // one finished result entry
  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] val;
    logic             sat;
    logic             singular;
  } lane_out_t;

endpackage

>>> rtl/m3i_front.sv
module m3i_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid,
  input  m3i_pkg::mat_t             mat,
  input  logic [m3i_pkg::THR_W-1:0] thr,
  output m3i_pkg::lane_in_t         lanes [m3i_pkg::N_LANE]
);
  import m3i_pkg::*;

  mat_t x;
  logic [5:0] vld;
  ent_t m [3][3];
  adj_t pa [9];
  adj_t pb [9];
  ent_t row0_1 [3];
  ent_t row0_2 [3];
  ent_t row0_3 [3];
  adj_t adj2 [9];
  adj_t adj3 [9];
  adj_t adj4 [9];
  adj_t adj5 [9];
  logic signed [ADJ_W:0]   plo [3];
  logic signed [ADJ_W-1:0] phi [3];
  logic signed [DET_W-1:0] det;
  logic signed [DET_W-1:0] det_next;
  logic [DMAG_W-1:0] dmag;
  logic [DMAG_W-1:0] dmag_next;
  logic [DMAG_W-1:0] thr_w;
  logic dneg;
  logic sing;

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], valid};
    end
  end

  // unpack the input item
  always_comb begin
    m[0][0] = x.m00; m[0][1] = x.m01; m[0][2] = x.m02;
    m[1][0] = x.m10; m[1][1] = x.m11; m[1][2] = x.m12;
    m[2][0] = x.m20; m[2][1] = x.m21; m[2][2] = x.m22;
  end

  // determinant: sum of the first-row terms, each split in two halves
  always_comb begin
    det_next = '0;
    for (int c = 0; c < 3; c++) begin
      det_next = det_next + (DET_W'(phi[c]) <<< ENT_W) + DET_W'(plo[c]);
    end
  end

  assign dneg      = det[DET_W-1];
  assign dmag_next = dneg ? DMAG_W'(-det) : DMAG_W'(det);
  assign thr_w     = DMAG_W'(thr) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      // S0: input register
      x <= mat;
      // S1: cofactor products
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pa[c*3+r] <= ADJ_W'(m[(r == 2) ? 0 : r + 1][(c == 2) ? 0 : c + 1]
                       * m[(r == 0) ? 2 : r - 1][(c == 0) ? 2 : c - 1]);
          pb[c*3+r] <= ADJ_W'(m[(r == 2) ? 0 : r + 1][(c == 0) ? 2 : c - 1]
                       * m[(r == 0) ? 2 : r - 1][(c == 2) ? 0 : c + 1]);
        end
        row0_1[r] <= m[0][r];
      end
      // S2: adjugate, transposed cofactors
      for (int i = 0; i < 9; i++) begin
        adj2[i] <= pa[i] - pb[i];
      end
      row0_2 <= row0_1;
      // S3: partial products of the first-row terms
      for (int c = 0; c < 3; c++) begin
        plo[c] <= (ADJ_W+1)'($signed({1'b0, adj2[c*3][ENT_W-1:0]}) * row0_2[c]);
        phi[c] <= ADJ_W'($signed(adj2[c*3][ADJ_W-1:ENT_W]) * row0_2[c]);
      end
      row0_3 <= row0_2;
      adj3   <= adj2;
      // S4: determinant
      det  <= det_next;
      adj4 <= adj3;
      // S5: magnitude and threshold test
      dmag <= dmag_next;
      sing <= !(dmag_next > thr_w);
      adj5 <= adj4;
    end
  end

  logic dneg5;
  always_ff @(posedge clk) begin
    if (en) begin
      dneg5 <= dneg;
    end
  end

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      lanes[i].valid    = vld[5];
      lanes[i].adj      = adj5[i];
      lanes[i].dmag     = dmag;
      lanes[i].dneg     = dneg5;
      lanes[i].singular = sing;
    end
  end

endmodule

>>> rtl/m3i_lane.sv
module m3i_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  m3i_pkg::lane_in_t  li,
  output m3i_pkg::lane_out_t lo
);
  import m3i_pkg::*;

  logic [ADJ_W-1:0] amag;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den0;
  logic [R0_W-1:0]  r0;
  logic [ADJ_W:0]   srnd;

  logic [REM_W-1:0] rem  [Q_W+1];
  logic [DEN_W-1:0] den  [Q_W+1];
  logic [Q_W-1:0]   nlo  [Q_W+1];
  logic [Q_W-1:0]   quo  [Q_W+1];
  logic [SV_W-1:0]  sval [Q_W+1];
  logic             ovf  [Q_W+1];
  logic             neg  [Q_W+1];
  logic             sing [Q_W+1];
  logic [Q_W:0]     vld;

  logic [REM_W-1:0] rs   [Q_W];
  logic             ge   [Q_W];

  logic [SV_W-1:0]  lim;
  logic [SV_W-1:0]  mag;
  logic             over;
  logic [ENT_W-1:0] v;

  // entry prep: rounding numerator, doubled divisor, singular-path value
  assign amag = li.adj[ADJ_W-1] ? ADJ_W'(-li.adj) : ADJ_W'(li.adj);
  assign num  = (NUM_W'(amag) << (2 * FRAC_BITS + 1)) + NUM_W'(li.dmag);
  assign den0 = {li.dmag, 1'b0};
  assign r0   = num[NUM_W-1:Q_W];
  assign srnd = (ADJ_W+1)'(amag) + ((ADJ_W+1)'(1) << (FRAC_BITS - 1));

  // one restoring step per stage
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      rs[k] = {rem[k][REM_W-2:0], nlo[k][Q_W-1]};
      ge[k] = rs[k] >= REM_W'(den[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-1:0], li.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= REM_W'(r0);
      den[0]  <= den0;
      nlo[0]  <= num[Q_W-1:0];
      quo[0]  <= '0;
      ovf[0]  <= REM_W'(r0) >= REM_W'(den0);
      sval[0] <= srnd[ADJ_W:FRAC_BITS];
      sing[0] <= li.singular;
      neg[0]  <= li.singular ? li.adj[ADJ_W-1] : (li.adj[ADJ_W-1] ^ li.dneg);
      for (int k = 0; k < Q_W; k++) begin
        rem[k+1]  <= ge[k] ? (rs[k] - REM_W'(den[k])) : rs[k];
        den[k+1]  <= den[k];
        nlo[k+1]  <= {nlo[k][Q_W-2:0], 1'b0};
        quo[k+1]  <= {quo[k][Q_W-2:0], ge[k]};
        ovf[k+1]  <= ovf[k];
        sval[k+1] <= sval[k];
        sing[k+1] <= sing[k];
        neg[k+1]  <= neg[k];
      end
    end
  end

  // clip to 32 bits
  assign lim  = neg[Q_W] ? (SV_W'(1) << (ENT_W - 1)) : ((SV_W'(1) << (ENT_W - 1)) - SV_W'(1));
  assign mag  = sing[Q_W] ? sval[Q_W] : SV_W'(quo[Q_W]);
  assign over = (!sing[Q_W] && ovf[Q_W]) || (mag > lim);
  assign v    = over ? lim[ENT_W-1:0] : mag[ENT_W-1:0];

  // lane output register
  always_ff @(posedge clk) begin
    if (rst) begin
      lo.valid <= 1'b0;
    end else if (en) begin
      lo.valid <= vld[Q_W];
    end
    if (en) begin
      lo.val      <= neg[Q_W] ? (ENT_W'(0) - v) : v;
      lo.sat      <= over;
      lo.singular <= sing[Q_W];
    end
  end

endmodule

>>> rtl/m3i_merge.sv
module m3i_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  m3i_pkg::lane_out_t lo [m3i_pkg::N_LANE],
  output logic               valid,
  output m3i_pkg::inv_t      inv
);
  import m3i_pkg::*;

  logic sat_any;

  // any clipped lane marks the item
  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < N_LANE; i++) begin
      sat_any = sat_any | lo[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= lo[0].valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      inv.r00       <= lo[0].val;
      inv.r01       <= lo[1].val;
      inv.r02       <= lo[2].val;
      inv.r10       <= lo[3].val;
      inv.r11       <= lo[4].val;
      inv.r12       <= lo[5].val;
      inv.r20       <= lo[6].val;
      inv.r21       <= lo[7].val;
      inv.r22       <= lo[8].val;
      inv.singular  <= lo[0].singular;
      inv.saturated <= sat_any;
    end
  end

endmodule

>>> rtl/matrix3x3_inverse.sv
// channel | dir | handshake             | item
// mat     | in  | mat_valid / mat_stall | 3x3 matrix, Q16.16, row-major
// inv     | out | inv_valid / inv_stall | inverse or adjugate, flags
// cfg     | in  | cfg_valid / cfg_ready | det_threshold write
//
// One matrix per cycle while no held result stalls the pipeline; 6 front stages, 35 per divider
// lane, which yields one quotient bit per restoring step, 1 output register.
// rst is synchronous; it empties the pipeline and sets the threshold to 7.
// A held result on inv freezes the whole pipeline and raises mat_stall.
// cfg_ready is always high.
module matrix3x3_inverse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mat_valid,
  output logic                      mat_stall,
  input  m3i_pkg::mat_t             mat,
  output logic                      inv_valid,
  input  logic                      inv_stall,
  output m3i_pkg::inv_t             inv,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [m3i_pkg::THR_W-1:0] cfg_data
);
  import m3i_pkg::*;

  logic             en;
  logic [THR_W-1:0] thr;
  lane_in_t         lanes [N_LANE];
  lane_out_t        res   [N_LANE];

  // pipeline advances unless a result is held
  assign en        = !(inv_valid && inv_stall);
  assign mat_stall = !en;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(THR_RST);
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  m3i_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .valid (mat_valid),
    .mat   (mat),
    .thr   (thr),
    .lanes (lanes)
  );

  // one divider per result entry
  for (genvar i = 0; i < N_LANE; i++) begin : g_lane
    m3i_lane u_lane (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .li  (lanes[i]),
      .lo  (res[i])
    );
  end

  m3i_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .lo    (res),
    .valid (inv_valid),
    .inv   (inv)
  );

endmodule

>>> sim/matrix3x3_inverse_check.sv
module matrix3x3_inverse_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mat_valid,
  input  logic                      mat_stall,
  input  m3i_pkg::mat_t             mat,
  input  logic                      inv_valid,
  input  logic                      inv_stall,
  input  m3i_pkg::inv_t             inv,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [m3i_pkg::THR_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending,
  output int                        n_checked,
  output int                        n_singular,
  output int                        n_saturated
);
  import m3i_pkg::*;

  logic [THR_W-1:0] det_thr;
  inv_t             inverse_q[$];
  int               n_reported;

  // exact adjugate, determinant, threshold test and rounded division
  function automatic inv_t invert(mat_t m, logic [THR_W-1:0] thr);
    logic [8:0][ENT_W-1:0] flat;
    logic [8:0][ENT_W-1:0] res;
    logic signed [65:0]    e[3][3];
    logic signed [65:0]    adj[3][3];
    logic signed [99:0]    det;
    logic [99:0]           dmag;
    logic [99:0]           thr_w;
    logic [65:0]           mag;
    logic [129:0]          q;
    logic [31:0]           lim;
    logic                  dneg, sing, sat, neg;
    int                    r1, r2, c1, c2;
    flat = m;
    sat  = 1'b0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        e[r][c] = $signed(flat[8 - (r * 3 + c)]);
    for (int r = 0; r < 3; r++) begin
      r1 = (r + 1) % 3;
      r2 = (r + 2) % 3;
      for (int c = 0; c < 3; c++) begin
        c1 = (c + 1) % 3;
        c2 = (c + 2) % 3;
        adj[c][r] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
      end
    end
    det = '0;
    for (int c = 0; c < 3; c++)
      det = det + adj[c][0] * e[0][c];
    dneg  = det[99];
    dmag  = dneg ? -det : det;
    thr_w = 100'(thr) << (2 * FRAC_BITS);
    sing  = !(dmag > thr_w);
    for (int k = 0; k < 9; k++) begin
      mag = adj[k / 3][k % 3][65] ? -adj[k / 3][k % 3] : adj[k / 3][k % 3];
      if (!sing) begin
        q   = ((130'(mag) << (2 * FRAC_BITS + 1)) + 130'(dmag)) / (130'(dmag) << 1);
        neg = adj[k / 3][k % 3][65] ^ dneg;
      end else begin
        q   = 130'((mag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        neg = adj[k / 3][k % 3][65];
      end
      lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      if (q > 130'(lim)) begin
        q   = 130'(lim);
        sat = 1'b1;
      end
      res[8 - k] = neg ? -q[31:0] : q[31:0];
    end
    return inv_t'({res, sing, sat});
  endfunction

  function automatic void note_bad(string fld, logic [31:0] want, logic [31:0] got);
    fails++;
    if (n_reported < 10) begin
      $display("item %0d field %s: expected %h, got %h", n_checked, fld, want, got);
      n_reported++;
    end
  endfunction

  // track the threshold, queue predictions, compare results
  always @(posedge clk) begin
    inv_t                  want;
    logic [8:0][ENT_W-1:0] wv, gv;
    if (rst) begin
      det_thr <= THR_W'(THR_RST);
    end else begin
      if (cfg_valid && cfg_ready)
        det_thr <= cfg_data;
      if (mat_valid && !mat_stall)
        inverse_q.push_back(invert(mat, det_thr));
      if (inv_valid && !inv_stall) begin
        if (inverse_q.size() == 0) begin
          fails++;
          if (n_reported < 10) begin
            $display("unexpected result %h", inv);
            n_reported++;
          end
        end else begin
          want = inverse_q.pop_front();
          wv   = want[289:2];
          gv   = inv[289:2];
          for (int k = 0; k < 9; k++)
            if (wv[8 - k] !== gv[8 - k])
              note_bad($sformatf("r%0d%0d", k / 3, k % 3), wv[8 - k], gv[8 - k]);
          if (want.singular !== inv.singular)
            note_bad("singular", want.singular, inv.singular);
          if (want.saturated !== inv.saturated)
            note_bad("saturated", want.saturated, inv.saturated);
          n_checked++;
          n_singular  += want.singular;
          n_saturated += want.saturated;
        end
      end
    end
    pending <= inverse_q.size();
  end

  initial begin
    fails       = 0;
    pending     = 0;
    n_checked   = 0;
    n_singular  = 0;
    n_saturated = 0;
    n_reported  = 0;
  end

endmodule

>>> sim/matrix3x3_inverse_test.sv
module matrix3x3_inverse_test;
  import m3i_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int ONE        = 1 << FRAC_BITS;

  logic             clk;
  logic             rst;
  logic             mat_valid;
  logic             mat_stall;
  mat_t             mat;
  logic             inv_valid;
  logic             inv_stall;
  inv_t             inv;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;
  int               fails, pending, n_checked, n_singular, n_saturated;
  int               idle_cycles;
  logic             calm;

  matrix3x3_inverse i_dut (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .mat       (mat),
    .inv_valid (inv_valid),
    .inv_stall (inv_stall),
    .inv       (inv),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  matrix3x3_inverse_check i_check (
    .clk         (clk),
    .rst         (rst),
    .mat_valid   (mat_valid),
    .mat_stall   (mat_stall),
    .mat         (mat),
    .inv_valid   (inv_valid),
    .inv_stall   (inv_stall),
    .inv         (inv),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .pending     (pending),
    .n_checked   (n_checked),
    .n_singular  (n_singular),
    .n_saturated (n_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one matrix from nine row-major entries
  function automatic mat_t build(int a, int b, int c, int d, int e, int f,
                                 int g, int h, int k);
    return mat_t'({a, b, c, d, e, f, g, h, k});
  endfunction

  // entry of a chosen magnitude class
  function automatic int rand_ent(int kind);
    case (kind)
      0:       return $urandom;
      1:       return $urandom_range(0, 1 << 19) - (1 << 18);
      2:       return $urandom_range(0, 1 << 24) - (1 << 23);
      default: return $urandom_range(0, 1 << 13) - (1 << 12);
    endcase
  endfunction

  function automatic mat_t rand_mat();
    int   v[9];
    int   kind, sel, s;
    kind = $urandom_range(0, 4);
    sel  = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      v[k] = rand_ent(kind == 4 ? $urandom_range(0, 3) : kind);
    // near-singular: one row a small multiple of another, at times plus a little noise
    if (sel < 3) begin
      s = $urandom_range(1, 4) * ($urandom_range(0, 1) ? 1 : -1);
      for (int c = 0; c < 3; c++)
        v[6 + c] = v[c] * s + ((sel == 0) ? $urandom_range(0, 4) - 2 : 0);
    end else if (sel == 3) begin
      v[0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return build(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endfunction

  task automatic send_mat(mat_t m);
    if (!calm && $urandom_range(0, 7) == 0) begin
      mat_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    mat       <= m;
    mat_valid <= 1'b1;
    do @(posedge clk); while (mat_stall);
  endtask

  task automatic drain();
    mat_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_mat(rand_mat());
    drain();
  endtask

  // result side stalls in bursts
  initial begin
    int burst;
    burst = 0;
    inv_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        inv_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        if (burst == 0)
          inv_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        inv_stall <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((mat_valid && !mat_stall) || (inv_valid && !inv_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    idle_cycles = 0;
    calm        = 1'b0;
    rst         = 1'b1;
    mat_valid   = 1'b0;
    mat         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset threshold
    send_mat(build(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_mat(build(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_mat(build(2 * ONE, 0, 0, 0, -ONE / 2, 0, 0, 0, 4 * ONE));
    send_mat(build(7, 0, 0, 0, ONE, 0, 0, 0, ONE));      // det equals threshold
    send_mat(build(8, 0, 0, 0, ONE, 0, 0, 0, ONE));      // just above it
    send_mat(build(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff));
    send_mat(build(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000));
    send_mat(build(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 0, 32'h7fffffff, 32'h80000000));
    send_mat(build(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000));
    send_mat(build(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_mat(build(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, -ONE, 5, 9));
    send_mat(build(2 * ONE, -ONE, 0, -ONE, 2 * ONE, -ONE, 0, -ONE, 2 * ONE));
    send_mat(build(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_mat(build(3, 0, 0, 0, 3, 0, 0, 0, 3));
    drain();

    // zero determinant with a zero threshold, then random items
    set_threshold('0);
    send_mat(build(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_mat(build(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_mat(build(1, 0, 0, 0, 1, 0, 0, 0, 1));
    random_phase(260);

    set_threshold({THR_W{1'b1}});
    send_mat(build(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000));
    random_phase(230);

    set_threshold(THR_W'(ONE));
    random_phase(230);

    set_threshold(THR_W'($urandom));
    random_phase(230);

    set_threshold(THR_W'($urandom_range(1, 1 << 10)));
    random_phase(200);

    // last part with no idling on either side
    calm = 1'b1;
    set_threshold(THR_W'(7));
    random_phase(230);

    repeat (60) @(posedge clk);
    $display("%0d matrices checked over six thresholds: %0d singular, %0d saturated",
             n_checked, n_singular, n_saturated);
    if (fails == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
